### hdl/pqbh_pkg.sv
// Shared types and constants for the per-query best-hit tracker.
`timescale 1ns / 1ps
package pqbh_pkg;

  localparam int DOM_BITS   = 14;
  localparam int LBL_BITS   = 16;
  localparam int SCORE_BITS = 64;
  localparam int COUNT_BITS = 32;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_HIT  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] CLS_IGNORED = 2'd0;
  localparam logic [1:0] CLS_TP      = 2'd1;
  localparam logic [1:0] CLS_XF      = 2'd2;
  localparam logic [1:0] CLS_NONE    = 2'd3;

  localparam logic REG_TRUTH_MODE   = 1'b0;
  localparam logic REG_SMALLER_WINS = 1'b1;

  typedef struct packed {
    logic [1:0]                   opcode;
    logic [DOM_BITS-1:0]          query_domain;
    logic [DOM_BITS-1:0]          target_domain;
    logic [LBL_BITS-1:0]          family_id;
    logic [LBL_BITS-1:0]          superfamily_id;
    logic [LBL_BITS-1:0]          fold_id;
    logic                         is_query;
    logic signed [SCORE_BITS-1:0] score;
  } req_t;

  typedef struct packed {
    logic [1:0]                   hit_class;
    logic                         has_tp;
    logic signed [SCORE_BITS-1:0] best_tp;
    logic                         has_xf;
    logic signed [SCORE_BITS-1:0] best_xf;
    logic [COUNT_BITS-1:0]        ignored_count;
    logic [COUNT_BITS-1:0]        considered_count;
  } rsp_t;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_HIT,
    KIND_READ
  } kind_e;

  // One decoded request waiting in the queue.
  typedef struct packed {
    kind_e                        kind;
    logic                         q_ok;
    logic                         t_ok;
    logic [DOM_BITS-1:0]          qd;
    logic [DOM_BITS-1:0]          td;
    logic [LBL_BITS-1:0]          fam;
    logic [LBL_BITS-1:0]          sfam;
    logic [LBL_BITS-1:0]          fold;
    logic                         is_query;
    logic signed [SCORE_BITS-1:0] score;
  } qentry_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

  typedef struct packed {
    logic truth_mode;
    logic smaller_wins;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } back_state_e;

endpackage

### hdl/pqbh_front.sv
// Front end: accepts requests, decodes them and holds them in a two-entry queue.
`timescale 1ns / 1ps
module pqbh_front import pqbh_pkg::*; #(
  parameter int DOMAINS = 16384
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_t      req,
  input  back_ctl_t ctl,
  output logic      head_valid,
  output qentry_t   head
);

  qentry_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  qentry_t    dec;

  // Decode the opcode; the unused code behaves as a read.
  always_comb begin
    case (req.opcode)
      OP_LOAD: dec.kind = KIND_LOAD;
      OP_HIT:  dec.kind = KIND_HIT;
      default: dec.kind = KIND_READ;
    endcase
    dec.q_ok     = 32'(req.query_domain) < 32'(DOMAINS);
    dec.t_ok     = 32'(req.target_domain) < 32'(DOMAINS);
    dec.qd       = req.query_domain;
    dec.td       = req.target_domain;
    dec.fam      = req.family_id;
    dec.sfam     = req.superfamily_id;
    dec.fold     = req.fold_id;
    dec.is_query = req.is_query;
    dec.score    = req.score;
  end

  assign req_ready  = !ctl.clearing && (count != 2'd2);
  assign push       = req_valid && req_ready;
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (ctl.pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(ctl.pop);
    end
  end

endmodule

### hdl/pqbh_back.sv
// Back end: entry memories, clearing pass, hit classification and best-score update.
`timescale 1ns / 1ps
module pqbh_back import pqbh_pkg::*; #(
  parameter int DOMAINS    = 16384,
  parameter int LABEL_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      head_valid,
  input  qentry_t   head,
  output back_ctl_t ctl,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_t      rsp
);

  localparam int AW = (DOMAINS > 1) ? $clog2(DOMAINS) : 1;
  localparam int LW = 3 * LABEL_BITS;

  // Status bits per entry: query flag, true-positive found, cross-fold found.
  localparam int S_QF = 0;
  localparam int S_TP = 1;
  localparam int S_XF = 2;

  logic [LW-1:0]         label_mem [DOMAINS];
  logic [2:0]            status_mem [DOMAINS];
  logic [SCORE_BITS-1:0] tp_mem [DOMAINS];
  logic [SCORE_BITS-1:0] xf_mem [DOMAINS];

  back_state_e state, state_next;
  logic [AW-1:0] clr_idx;
  qentry_t       item;

  logic [LW-1:0]         lab_q, lab_t;
  logic [2:0]            st_rd;
  logic signed [SCORE_BITS-1:0] tp_rd, xf_rd;

  logic [COUNT_BITS-1:0] ignored_total, considered_total;

  logic          pop, fire;
  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [2:0]    st_wdata;
  logic [AW-1:0] rd_q, rd_t, iq;

  logic fam_eq, sfam_eq, fold_eq, excl_eq, truth_eq;
  logic hit_go, is_ign, is_tp, is_xf, upd_tp, upd_xf, better_tp, better_xf;
  logic is_load;
  logic [2:0] st_new;
  logic [LW-1:0] load_word;
  logic [1:0] cls;

  assign rd_q = AW'(head.qd);
  assign rd_t = AW'(head.td);
  assign iq   = AW'(item.qd);

  assign ctl.pop      = pop;
  assign ctl.clearing = (state == ST_CLEAR);

  // Classification of the held item against the registered read data.
  always_comb begin
    fam_eq    = lab_q[LABEL_BITS-1:0] == lab_t[LABEL_BITS-1:0];
    sfam_eq   = lab_q[2*LABEL_BITS-1:LABEL_BITS] == lab_t[2*LABEL_BITS-1:LABEL_BITS];
    fold_eq   = lab_q[LW-1:2*LABEL_BITS] == lab_t[LW-1:2*LABEL_BITS];
    excl_eq   = cfg.truth_mode ? sfam_eq : fam_eq;
    truth_eq  = cfg.truth_mode ? fold_eq : sfam_eq;
    hit_go    = (item.kind == KIND_HIT) && item.q_ok && item.t_ok && st_rd[S_QF];
    is_ign    = hit_go && ((item.qd == item.td) || excl_eq);
    is_tp     = hit_go && !is_ign && truth_eq;
    is_xf     = hit_go && !is_ign && !truth_eq;
    better_tp = cfg.smaller_wins ? (item.score < tp_rd) : (item.score > tp_rd);
    better_xf = cfg.smaller_wins ? (item.score < xf_rd) : (item.score > xf_rd);
    upd_tp    = is_tp && (!st_rd[S_TP] || better_tp);
    upd_xf    = is_xf && (!st_rd[S_XF] || better_xf);
    is_load   = (item.kind == KIND_LOAD) && item.q_ok;

    st_new       = st_rd;
    st_new[S_TP] = st_rd[S_TP] | is_tp;
    st_new[S_XF] = st_rd[S_XF] | is_xf;
    if (is_load) begin
      st_new[S_QF] = item.is_query;
    end

    load_word = {item.fold[LABEL_BITS-1:0], item.sfam[LABEL_BITS-1:0],
                 item.fam[LABEL_BITS-1:0]};

    if (is_ign) begin
      cls = CLS_IGNORED;
    end else if (is_tp) begin
      cls = CLS_TP;
    end else if (is_xf) begin
      cls = CLS_XF;
    end else begin
      cls = CLS_NONE;
    end
  end

  // Sequencer: clearing pass, then pop one item, read, and evaluate/write back.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    fire       = 1'b0;
    st_we      = 1'b0;
    st_waddr   = iq;
    st_wdata   = st_new;
    case (state)
      ST_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_idx;
        st_wdata = 3'b000;
        if (clr_idx == AW'(DOMAINS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head_valid) begin
          pop        = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!rsp_valid || rsp_ready) begin
          fire       = 1'b1;
          st_we      = is_load || hit_go;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + AW'(1);
      end
    end
  end

  // Entry memories: one write port each, registered reads.
  always_ff @(posedge clk) begin
    if (pop) begin
      item  <= head;
      lab_q <= label_mem[rd_q];
      lab_t <= label_mem[rd_t];
      st_rd <= status_mem[rd_q];
      tp_rd <= tp_mem[rd_q];
      xf_rd <= xf_mem[rd_q];
    end
    if (st_we) begin
      status_mem[st_waddr] <= st_wdata;
    end
    if (fire && is_load) begin
      label_mem[iq] <= load_word;
    end
    if (fire && upd_tp) begin
      tp_mem[iq] <= item.score;
    end
    if (fire && upd_xf) begin
      xf_mem[iq] <= item.score;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ignored_total    <= '0;
      considered_total <= '0;
      rsp_valid        <= 1'b0;
    end else begin
      if (fire && is_ign && (ignored_total != '1)) begin
        ignored_total <= ignored_total + COUNT_BITS'(1);
      end
      if (fire && (is_tp || is_xf) && (considered_total != '1)) begin
        considered_total <= considered_total + COUNT_BITS'(1);
      end
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.hit_class <= cls;
      rsp.has_tp    <= item.q_ok && st_new[S_TP];
      rsp.has_xf    <= item.q_ok && st_new[S_XF];
      rsp.best_tp   <= !(item.q_ok && st_new[S_TP]) ? '0 : (upd_tp ? item.score : tp_rd);
      rsp.best_xf   <= !(item.q_ok && st_new[S_XF]) ? '0 : (upd_xf ? item.score : xf_rd);
      rsp.ignored_count <= ((is_ign && (ignored_total != '1)) ?
                            ignored_total + COUNT_BITS'(1) : ignored_total);
      rsp.considered_count <= (((is_tp || is_xf) && (considered_total != '1)) ?
                               considered_total + COUNT_BITS'(1) : considered_total);
    end
  end

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !pop)
    else $error("item popped during the clearing pass");

  a_counters_only_on_eval: assert property (@(posedge clk) disable iff (rst)
    (!rst && (state != ST_EVAL)) |=> ($stable(ignored_total) && $stable(considered_total)))
    else $error("hit counters moved outside evaluation");

  a_ignored_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (ignored_total >= $past(ignored_total)))
    else $error("ignored count decreased");

  a_fire_needs_room: assert property (@(posedge clk) disable iff (rst)
    fire |-> (!rsp_valid || rsp_ready))
    else $error("result overwritten before it was taken");

endmodule

### hdl/per_query_best_hit_by_category.sv
// Top level of the per-query best-hit tracker: configuration port and front/back split.
`timescale 1ns / 1ps
// Flow: an accepted request waits in the queue, is popped as the entry memories are read,
// then evaluated, written back and registered as rsp; the back end takes one at a time.
// The two-entry queue keeps taking requests until full while a result waits on rsp_ready.
// Reset: synchronous; then a clearing pass over every entry zeroes the query and
// found flags, with req_ready low throughout. Configuration writes are taken at any time.
module per_query_best_hit_by_category import pqbh_pkg::*; #(
  parameter int DOMAINS    = 16384,
  parameter int LABEL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp
);

  // The two configuration bits. The user must change them only while the block is idle;
  // the block itself does not enforce this, and the back end reads them directly.
  cfg_t      cfg;
  logic      cfg_wr;
  back_ctl_t ctl;
  logic      head_valid;
  qentry_t   head;

  // The port never inserts wait states; a write lands at the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.truth_mode   <= 1'b0;
      cfg.smaller_wins <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_TRUTH_MODE:   cfg.truth_mode   <= pwdata[0];
        REG_SMALLER_WINS: cfg.smaller_wins <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back: each register sits in bit 0 of its word.
  always_comb begin
    case (paddr[2])
      REG_TRUTH_MODE:   prdata = {31'b0, cfg.truth_mode};
      REG_SMALLER_WINS: prdata = {31'b0, cfg.smaller_wins};
      default:          prdata = '0;
    endcase
  end

  // The front end decodes each request and queues it; it stalls only when
  // the queue is full or the clearing pass is running.
  pqbh_front #(
    .DOMAINS(DOMAINS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .ctl       (ctl),
    .head_valid(head_valid),
    .head      (head)
  );

  // The back end owns the label, status and best-score memories and the hit
  // counters, and holds each result in an output register until taken.
  pqbh_back #(
    .DOMAINS   (DOMAINS),
    .LABEL_BITS(LABEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head_valid(head_valid),
    .head      (head),
    .ctl       (ctl),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
